>>> hw/rtl/mstd_pkg.sv
package mstd_pkg;

   // sample and list sizes
   localparam int SAMPLE_W    = 16;
   localparam int MAX_SAMPLES = 1024;
   localparam int FRAC_BITS   = 8;
   localparam int COUNT_W     = $clog2(MAX_SAMPLES + 1);

   // result field widths
   localparam int MEAN_W = 24;
   localparam int STD_W  = 24;

   // accumulator widths
   localparam int SUM_W = SAMPLE_W + COUNT_W - 1;
   localparam int SQ_W  = 2 * SAMPLE_W + COUNT_W - 2;

   // back end arithmetic widths
   localparam int M_W    = SAMPLE_W + 1;
   localparam int NM_W   = COUNT_W + 1 + M_W;
   localparam int D_W    = NM_W + 1;
   localparam int MD_W   = M_W + D_W;
   localparam int TOTS_W = MD_W + 1;
   localparam int TOT_W  = SQ_W + 1;

   // shared divider and square root
   localparam int DIV_W   = TOT_W + 2 * FRAC_BITS;
   localparam int DCNT_W  = $clog2(DIV_W + 1);
   localparam int ROOT_W  = (DIV_W + 1) / 2;
   localparam int RAD_W   = 2 * ROOT_W;
   localparam int SREM_W  = ROOT_W + 2;
   localparam int SCNT_W  = $clog2(ROOT_W + 1);

   // queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QFILL_W     = $clog2(QUEUE_DEPTH + 1);

   // totals of one closed list
   typedef struct packed {
      logic signed [SUM_W-1:0] sum;
      logic [SQ_W-1:0]         square_sum;
      logic [COUNT_W-1:0]      count;
      logic                    too_many;
   } list_totals_type;

   typedef struct packed {
      logic not_empty;
      logic full;
   } q_stat_type;

   typedef struct packed {
      logic               start;
      logic [DIV_W-1:0]   dividend;
      logic [COUNT_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [DIV_W-1:0] quotient;
   } div_rsp_type;

endpackage

>>> hw/rtl/mstd_front.sv
module mstd_front (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic signed [mstd_pkg::SAMPLE_W-1:0]  req_sample,
   input  logic                                  req_sample_last,
   input  mstd_pkg::q_stat_type                  q_stat,
   output logic                                  push,
   output mstd_pkg::list_totals_type             push_data
);

   logic signed [mstd_pkg::SUM_W-1:0] sum_ff, sum_in, sum_new;
   logic [mstd_pkg::SQ_W-1:0]         sq_ff, sq_in, sq_new;
   logic [mstd_pkg::COUNT_W-1:0]      count_ff, count_in, count_new;
   logic                              ovf_ff, ovf_in, ovf_new;
   logic signed [2*mstd_pkg::SAMPLE_W-1:0] square;
   logic                              room;
   logic                              accept;

   // accumulate one word, close the list on the last one
   always_comb begin
      accept    = req_valid && !q_stat.full;
      req_ready = !q_stat.full;
      room      = count_ff < mstd_pkg::COUNT_W'(mstd_pkg::MAX_SAMPLES);
      square    = req_sample * req_sample;
      sum_new   = sum_ff;
      sq_new    = sq_ff;
      count_new = count_ff;
      ovf_new   = ovf_ff;
      if (room) begin
         sum_new   = sum_ff + mstd_pkg::SUM_W'(req_sample);
         sq_new    = sq_ff + mstd_pkg::SQ_W'($unsigned(square));
         count_new = count_ff + mstd_pkg::COUNT_W'(1);
      end else begin
         ovf_new = 1'b1;
      end
      push                 = accept && req_sample_last;
      push_data.sum        = sum_new;
      push_data.square_sum = sq_new;
      push_data.count      = count_new;
      push_data.too_many   = ovf_new;
      sum_in   = sum_ff;
      sq_in    = sq_ff;
      count_in = count_ff;
      ovf_in   = ovf_ff;
      if (accept) begin
         if (req_sample_last) begin
            sum_in   = '0;
            sq_in    = '0;
            count_in = '0;
            ovf_in   = 1'b0;
         end else begin
            sum_in   = sum_new;
            sq_in    = sq_new;
            count_in = count_new;
            ovf_in   = ovf_new;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff   <= '0;
         sq_ff    <= '0;
         count_ff <= '0;
         ovf_ff   <= 1'b0;
      end else begin
         sum_ff   <= sum_in;
         sq_ff    <= sq_in;
         count_ff <= count_in;
         ovf_ff   <= ovf_in;
      end
   end

endmodule

>>> hw/rtl/mstd_queue.sv
module mstd_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  mstd_pkg::list_totals_type push_data,
   input  logic                      pop,
   output mstd_pkg::list_totals_type head,
   output mstd_pkg::q_stat_type      q_stat
);

   mstd_pkg::list_totals_type      entry_ff [mstd_pkg::QUEUE_DEPTH];
   logic [mstd_pkg::QPTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [mstd_pkg::QPTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [mstd_pkg::QFILL_W-1:0]   fill_ff, fill_in;

   // pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == mstd_pkg::QPTR_W'(mstd_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + mstd_pkg::QPTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == mstd_pkg::QPTR_W'(mstd_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + mstd_pkg::QPTR_W'(1);
      end
      if (push && !pop) begin
         fill_in = fill_ff + mstd_pkg::QFILL_W'(1);
      end else if (pop && !push) begin
         fill_in = fill_ff - mstd_pkg::QFILL_W'(1);
      end
      head             = entry_ff[rd_ptr_ff];
      q_stat.not_empty = fill_ff != '0;
      q_stat.full      = fill_ff == mstd_pkg::QFILL_W'(mstd_pkg::QUEUE_DEPTH);
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

endmodule

>>> hw/rtl/mstd_divider.sv
module mstd_divider (
   input  logic                  clock,
   input  logic                  reset,
   input  mstd_pkg::div_req_type div_req,
   output mstd_pkg::div_rsp_type div_rsp
);

   logic [mstd_pkg::DIV_W-1:0]   acc_ff, acc_in;
   logic [mstd_pkg::COUNT_W-1:0] rem_ff, rem_in;
   logic [mstd_pkg::COUNT_W-1:0] divisor_ff, divisor_in;
   logic [mstd_pkg::DCNT_W-1:0]  cnt_ff, cnt_in;
   logic                         busy_ff, busy_in;
   logic                         done_ff, done_in;
   logic [mstd_pkg::COUNT_W:0]   rem_shift;
   logic                         fits;

   // restoring division, one quotient bit a cycle, quotient shifts in behind the dividend
   always_comb begin
      rem_shift  = {rem_ff, acc_ff[mstd_pkg::DIV_W-1]};
      fits       = rem_shift >= {1'b0, divisor_ff};
      acc_in     = acc_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      cnt_in     = cnt_ff;
      busy_in    = busy_ff;
      done_in    = 1'b0;
      if (div_req.start) begin
         acc_in     = div_req.dividend;
         rem_in     = '0;
         divisor_in = div_req.divisor;
         cnt_in     = '0;
         busy_in    = 1'b1;
      end else if (busy_ff) begin
         acc_in = {acc_ff[mstd_pkg::DIV_W-2:0], fits};
         rem_in = fits ? mstd_pkg::COUNT_W'(rem_shift - {1'b0, divisor_ff}) :
                         mstd_pkg::COUNT_W'(rem_shift);
         cnt_in = cnt_ff + mstd_pkg::DCNT_W'(1);
         if (cnt_ff == mstd_pkg::DCNT_W'(mstd_pkg::DIV_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
      div_rsp.done     = done_ff;
      div_rsp.quotient = acc_ff;
   end

   always_ff @(posedge clock) begin
      acc_ff     <= acc_in;
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
      cnt_ff     <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

endmodule

>>> hw/rtl/mstd_back.sv
module mstd_back (
   input  logic                                clock,
   input  logic                                reset,
   input  mstd_pkg::q_stat_type                q_stat,
   input  mstd_pkg::list_totals_type           head,
   output logic                                pop,
   output mstd_pkg::div_req_type               div_req,
   input  mstd_pkg::div_rsp_type               div_rsp,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [mstd_pkg::MEAN_W-1:0]  rsp_mean_q8,
   output logic [mstd_pkg::STD_W-1:0]          rsp_std_q8,
   output logic [mstd_pkg::COUNT_W-1:0]        rsp_sample_count,
   output logic                                rsp_too_many
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV_MEAN,
      ST_MUL_NM,
      ST_MUL_MD,
      ST_LOAD_VAR,
      ST_DIV_VAR,
      ST_SQRT,
      ST_DONE
   } back_state_type;

   back_state_type                      state_ff, state_in;
   mstd_pkg::list_totals_type           entry_ff, entry_in;
   logic                                neg_ff, neg_in;
   logic signed [mstd_pkg::MEAN_W-1:0]  mean_ff, mean_in;
   logic signed [mstd_pkg::M_W-1:0]     m_ff, m_in;
   logic signed [mstd_pkg::NM_W-1:0]    nm_ff, nm_in;
   logic signed [mstd_pkg::MD_W-1:0]    md_ff, md_in;
   logic [mstd_pkg::RAD_W-1:0]          rad_ff, rad_in;
   logic [mstd_pkg::SREM_W-1:0]         srem_ff, srem_in;
   logic [mstd_pkg::ROOT_W-1:0]         root_ff, root_in;
   logic [mstd_pkg::SCNT_W-1:0]         scnt_ff, scnt_in;
   logic                                rsp_valid_ff, rsp_valid_in;
   logic signed [mstd_pkg::MEAN_W-1:0]  rsp_mean_ff, rsp_mean_in;
   logic [mstd_pkg::STD_W-1:0]          rsp_std_ff, rsp_std_in;
   logic [mstd_pkg::COUNT_W-1:0]        rsp_count_ff, rsp_count_in;
   logic                                rsp_many_ff, rsp_many_in;

   logic [mstd_pkg::SUM_W-1:0]          sum_mag;
   logic [mstd_pkg::MEAN_W-1:0]         q_low;
   logic [mstd_pkg::M_W-1:0]            m_mag;
   logic signed [mstd_pkg::NM_W-1:0]    n_signed;
   logic signed [mstd_pkg::D_W-1:0]     d_val;
   logic signed [mstd_pkg::TOTS_W-1:0]  tot_s;
   logic [mstd_pkg::TOT_W-1:0]          tot;
   logic [mstd_pkg::SREM_W-1:0]         srem_shift;
   logic [mstd_pkg::SREM_W-1:0]         trial;
   logic                                s_fits;

   always_comb begin
      // datapath pieces
      sum_mag  = head.sum[mstd_pkg::SUM_W-1] ? mstd_pkg::SUM_W'(-head.sum) :
                                               mstd_pkg::SUM_W'(head.sum);
      q_low    = div_rsp.quotient[mstd_pkg::MEAN_W-1:0];
      m_mag    = div_rsp.quotient[mstd_pkg::FRAC_BITS +: mstd_pkg::M_W];
      n_signed = $signed(mstd_pkg::NM_W'(entry_ff.count));
      d_val    = (mstd_pkg::D_W'(entry_ff.sum) <<< 1) - mstd_pkg::D_W'(nm_ff);
      tot_s    = $signed(mstd_pkg::TOTS_W'(entry_ff.square_sum)) -
                 mstd_pkg::TOTS_W'(md_ff);
      tot      = tot_s[mstd_pkg::TOTS_W-1] ? '0 : tot_s[mstd_pkg::TOT_W-1:0];
      // square root: two radicand bits a step
      srem_shift = {srem_ff[mstd_pkg::SREM_W-3:0], rad_ff[mstd_pkg::RAD_W-1 -: 2]};
      trial      = {root_ff, 2'b01};
      s_fits     = srem_shift >= trial;

      // defaults
      state_in     = state_ff;
      entry_in     = entry_ff;
      neg_in       = neg_ff;
      mean_in      = mean_ff;
      m_in         = m_ff;
      nm_in        = nm_ff;
      md_in        = md_ff;
      rad_in       = rad_ff;
      srem_in      = srem_ff;
      root_in      = root_ff;
      scnt_in      = scnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_mean_in  = rsp_mean_ff;
      rsp_std_in   = rsp_std_ff;
      rsp_count_in = rsp_count_ff;
      rsp_many_in  = rsp_many_ff;
      pop              = 1'b0;
      div_req.start    = 1'b0;
      div_req.dividend = mstd_pkg::DIV_W'(sum_mag) << mstd_pkg::FRAC_BITS;
      div_req.divisor  = head.count;

      case (state_ff)
         // take a list and start the mean division
         ST_IDLE: begin
            if (q_stat.not_empty) begin
               pop           = 1'b1;
               entry_in      = head;
               neg_in        = head.sum[mstd_pkg::SUM_W-1];
               div_req.start = 1'b1;
               state_in      = ST_DIV_MEAN;
            end
         end
         // mean in fixed point, integer mean from its upper bits
         ST_DIV_MEAN: begin
            if (div_rsp.done) begin
               mean_in  = neg_ff ? -$signed(q_low) : $signed(q_low);
               m_in     = neg_ff ? -$signed(m_mag) : $signed(m_mag);
               state_in = ST_MUL_NM;
            end
         end
         ST_MUL_NM: begin
            nm_in    = n_signed * mstd_pkg::NM_W'(m_ff);
            state_in = ST_MUL_MD;
         end
         // m * (2*sum - n*m)
         ST_MUL_MD: begin
            md_in    = mstd_pkg::MD_W'(m_ff) * mstd_pkg::MD_W'(d_val);
            state_in = ST_LOAD_VAR;
         end
         // deviation total scaled up, divided by the count
         ST_LOAD_VAR: begin
            div_req.start    = 1'b1;
            div_req.dividend = mstd_pkg::DIV_W'(tot) << (2 * mstd_pkg::FRAC_BITS);
            div_req.divisor  = entry_ff.count;
            state_in         = ST_DIV_VAR;
         end
         ST_DIV_VAR: begin
            if (div_rsp.done) begin
               rad_in   = mstd_pkg::RAD_W'(div_rsp.quotient);
               srem_in  = '0;
               root_in  = '0;
               scnt_in  = '0;
               state_in = ST_SQRT;
            end
         end
         ST_SQRT: begin
            rad_in  = rad_ff << 2;
            srem_in = s_fits ? srem_shift - trial : srem_shift;
            root_in = {root_ff[mstd_pkg::ROOT_W-2:0], s_fits};
            scnt_in = scnt_ff + mstd_pkg::SCNT_W'(1);
            if (scnt_ff == mstd_pkg::SCNT_W'(mstd_pkg::ROOT_W - 1)) begin
               state_in = ST_DONE;
            end
         end
         // hand over to the output register once it is free
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_mean_in  = mean_ff;
               rsp_std_in   = root_ff[mstd_pkg::STD_W-1:0];
               rsp_count_in = entry_ff.count;
               rsp_many_in  = entry_ff.too_many;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_valid        = rsp_valid_ff;
      rsp_mean_q8      = rsp_mean_ff;
      rsp_std_q8       = rsp_std_ff;
      rsp_sample_count = rsp_count_ff;
      rsp_too_many     = rsp_many_ff;
   end

   always_ff @(posedge clock) begin
      entry_ff     <= entry_in;
      neg_ff       <= neg_in;
      mean_ff      <= mean_in;
      m_ff         <= m_in;
      nm_ff        <= nm_in;
      md_ff        <= md_in;
      rad_ff       <= rad_in;
      srem_ff      <= srem_in;
      root_ff      <= root_in;
      scnt_ff      <= scnt_in;
      rsp_mean_ff  <= rsp_mean_in;
      rsp_std_ff   <= rsp_std_in;
      rsp_count_ff <= rsp_count_in;
      rsp_many_ff  <= rsp_many_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

>>> hw/rtl/mean_and_std_deviation_core.sv
// mean and population standard deviation of a list of signed 16-bit samples
//
// req channel: one sample word per handshake, req_sample_last closes the list.
// Samples accumulate into a count, sum and sum of squares at one word per
// cycle while req_ready is high; words beyond 1024 in a list are dropped
// and reported through rsp_too_many. rsp channel: one word per list with the
// Q8 mean (truncated toward zero), the Q8 population standard deviation around
// the truncated integer mean (floor), the sample count and the overflow flag.
// After the last word is taken, its list totals pass through the queue to the
// back end, which runs two passes of a bit-serial divider, a bit-serial square
// root and the multiply states ST_MUL_NM and ST_MUL_MD, one list at a time. A
// two-entry queue of list totals sits between the accumulator and the
// back end, so samples of later lists keep flowing at one per cycle; req_ready
// only drops while that queue is full.
// A stalled receiver holds the result in the output register; the back end
// keeps working on the next list meanwhile.
// Reset clears the accumulators, empties the queue and drops rsp_valid.
module mean_and_std_deviation_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [mstd_pkg::SAMPLE_W-1:0] req_sample,
   input  logic                                req_sample_last,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [mstd_pkg::MEAN_W-1:0]  rsp_mean_q8,
   output logic [mstd_pkg::STD_W-1:0]          rsp_std_q8,
   output logic [mstd_pkg::COUNT_W-1:0]        rsp_sample_count,
   output logic                                rsp_too_many
);

   mstd_pkg::q_stat_type      q_stat;
   mstd_pkg::list_totals_type push_data;
   mstd_pkg::list_totals_type head;
   mstd_pkg::div_req_type     div_req;
   mstd_pkg::div_rsp_type     div_rsp;
   logic                      push;
   logic                      pop;

   // accumulation front end
   mstd_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_sample      (req_sample),
      .req_sample_last (req_sample_last),
      .q_stat          (q_stat),
      .push            (push),
      .push_data       (push_data)
   );

   // closed lists waiting for the back end
   mstd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .head      (head),
      .q_stat    (q_stat)
   );

   // shared serial divider
   mstd_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // statistics back end and output register
   mstd_back u_back (
      .clock            (clock),
      .reset            (reset),
      .q_stat           (q_stat),
      .head             (head),
      .pop              (pop),
      .div_req          (div_req),
      .div_rsp          (div_rsp),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_mean_q8      (rsp_mean_q8),
      .rsp_std_q8       (rsp_std_q8),
      .rsp_sample_count (rsp_sample_count),
      .rsp_too_many     (rsp_too_many)
   );

endmodule

>>> hw/rtl/mstd_checker.sv
module mstd_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_ready,
   input logic signed [mstd_pkg::SAMPLE_W-1:0] req_sample,
   input logic                                req_sample_last,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic signed [mstd_pkg::MEAN_W-1:0]  rsp_mean_q8,
   input logic [mstd_pkg::STD_W-1:0]          rsp_std_q8,
   input logic [mstd_pkg::COUNT_W-1:0]        rsp_sample_count,
   input logic                                rsp_too_many
);

   // a stalled result word holds still
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_mean_q8) &&
      $stable(rsp_std_q8) && $stable(rsp_sample_count) && $stable(rsp_too_many))
      else $error("result word changed while stalled");

   // dropped samples only once the list is full
   a_overflow_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_too_many |->
      rsp_sample_count == mstd_pkg::COUNT_W'(mstd_pkg::MAX_SAMPLES))
      else $error("overflow flagged on a list below capacity");

   // a single sample has no spread
   a_single_zero_std: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_sample_count == mstd_pkg::COUNT_W'(1) |-> rsp_std_q8 == '0)
      else $error("nonzero deviation for a one-sample list");

   // reset leaves no result pending
   a_reset_clear: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind mean_and_std_deviation_core mstd_checker u_checker (.*);

>>> bench/mean_and_std_deviation_core_tb.sv
module mean_and_std_deviation_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DIRECTED_ROWS   = 21;
   localparam int RANDOM_ITEMS    = 1550;
   localparam int BIG_LIST_AT     = 300;
   localparam int BIG_LIST_EXTRA  = 3;
   localparam int CALM_FROM       = 120;
   localparam int CALM_TO         = 290;
   localparam int RSP_HOLD_CYCLES = 3000;
   localparam int DRAIN_CYCLES    = 400;
   localparam int IDLE_LIMIT      = 20000;
   localparam int IDLE_PERCENT    = 21;

   // one result word of a closed list
   typedef struct packed {
      logic signed [mstd_pkg::MEAN_W-1:0] mean_q8;
      logic [mstd_pkg::STD_W-1:0]         std_q8;
      logic [mstd_pkg::COUNT_W-1:0]       sample_count;
      logic                               too_many;
   } list_stats_type;

   // one row of the directed table; given rows carry their own result
   typedef struct packed {
      logic signed [mstd_pkg::SAMPLE_W-1:0] sample;
      logic                                 last;
      logic                                 given;
      list_stats_type                       want;
   } directed_row_type;

   typedef enum int {STYLE_WIDE, STYLE_NEAR_ZERO, STYLE_EXTREME, STYLE_FLAT} sample_style_type;

   localparam list_stats_type NO_STATS = '0;

   logic                                 clock = 1'b0;
   logic                                 reset;
   logic                                 req_valid;
   logic                                 req_ready;
   logic signed [mstd_pkg::SAMPLE_W-1:0] req_sample;
   logic                                 req_sample_last;
   logic                                 rsp_valid;
   logic                                 rsp_ready;
   logic signed [mstd_pkg::MEAN_W-1:0]   rsp_mean_q8;
   logic [mstd_pkg::STD_W-1:0]           rsp_std_q8;
   logic [mstd_pkg::COUNT_W-1:0]         rsp_sample_count;
   logic                                 rsp_too_many;

   // running totals of the list being gathered
   longint         acc_sum;
   longint         acc_square_sum;
   int unsigned    acc_count;
   bit             acc_dropped;

   list_stats_type pending_stats[$];
   int             mismatch_count;
   int             quiet_cycles;
   bit             idling_on;
   bit             rsp_hold_req;
   bit             rsp_hold_done;

   directed_row_type directed_rows [DIRECTED_ROWS] = '{
      '{16'sh7FFF, 1'b1, 1'b1, '{24'sd8388352, 24'd0, 11'd1, 1'b0}},
      '{16'sh8000, 1'b1, 1'b1, '{24'sh800000, 24'd0, 11'd1, 1'b0}},
      '{16'sd0, 1'b1, 1'b1, '{24'sd0, 24'd0, 11'd1, 1'b0}},
      '{-16'sd1, 1'b1, 1'b1, '{-24'sd256, 24'd0, 11'd1, 1'b0}},
      '{16'sh7FFF, 1'b0, 1'b0, NO_STATS},
      '{16'sh8000, 1'b1, 1'b0, NO_STATS},
      '{-16'sd1, 1'b0, 1'b0, NO_STATS},
      '{16'sd0, 1'b0, 1'b0, NO_STATS},
      '{16'sd0, 1'b1, 1'b0, NO_STATS},
      '{16'sd3, 1'b0, 1'b0, NO_STATS},
      '{16'sd4, 1'b0, 1'b0, NO_STATS},
      '{16'sd5, 1'b1, 1'b0, NO_STATS},
      '{-16'sd7, 1'b0, 1'b0, NO_STATS},
      '{-16'sd7, 1'b0, 1'b0, NO_STATS},
      '{-16'sd7, 1'b1, 1'b1, '{-24'sd1792, 24'd0, 11'd3, 1'b0}},
      '{16'sd1, 1'b0, 1'b0, NO_STATS},
      '{16'sd2, 1'b1, 1'b0, NO_STATS},
      '{16'sh8000, 1'b0, 1'b0, NO_STATS},
      '{16'sh8001, 1'b1, 1'b0, NO_STATS},
      '{16'sh5555, 1'b0, 1'b0, NO_STATS},
      '{16'shAAAA, 1'b1, 1'b0, NO_STATS}
   };

   mean_and_std_deviation_core dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_sample       (req_sample),
      .req_sample_last  (req_sample_last),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_mean_q8      (rsp_mean_q8),
      .rsp_std_q8       (rsp_std_q8),
      .rsp_sample_count (rsp_sample_count),
      .rsp_too_many     (rsp_too_many)
   );

   always #5 clock = ~clock;

   // bit by bit integer square root, floor
   function automatic longint unsigned floor_sqrt(input longint unsigned v);
      longint unsigned root;
      longint unsigned trial;
      root = 0;
      for (int b = 31; b >= 0; b--) begin
         trial = root | (64'd1 << b);
         if (trial * trial <= v) begin
            root = trial;
         end
      end
      return root;
   endfunction

   // add one sample to the list totals; on the last sample work out the stats word
   task automatic fold_sample(input logic signed [mstd_pkg::SAMPLE_W-1:0] s,
                              input logic last,
                              output bit closes, output list_stats_type stats);
      longint          n;
      longint          int_mean;
      longint          spread;
      longint          mean_fx;
      longint unsigned uspread;
      longint unsigned un;
      longint unsigned scaled;
      longint unsigned root;
      if (acc_count < mstd_pkg::MAX_SAMPLES) begin
         acc_sum        += longint'(s);
         acc_square_sum += longint'(s) * longint'(s);
         acc_count++;
      end else begin
         acc_dropped = 1'b1;
      end
      closes = last;
      stats  = '0;
      if (last) begin
         if (acc_count != 0) begin
            n        = acc_count;
            un       = acc_count;
            int_mean = acc_sum / n;
            // squared deviation around the truncated integer mean
            spread   = acc_square_sum - 2 * int_mean * acc_sum + n * int_mean * int_mean;
            mean_fx  = (acc_sum * (longint'(1) << mstd_pkg::FRAC_BITS)) / n;
            if (spread < 0) begin
               spread = 0;
            end
            uspread = spread;
            scaled  = ((uspread / un) << (2 * mstd_pkg::FRAC_BITS))
                      + (((uspread % un) << (2 * mstd_pkg::FRAC_BITS)) / un);
            root    = floor_sqrt(scaled);
            stats.mean_q8 = mean_fx[mstd_pkg::MEAN_W-1:0];
            stats.std_q8  = root[mstd_pkg::STD_W-1:0];
         end
         stats.sample_count = acc_count[mstd_pkg::COUNT_W-1:0];
         stats.too_many     = acc_dropped;
         acc_sum        = 0;
         acc_square_sum = 0;
         acc_count      = 0;
         acc_dropped    = 1'b0;
      end
   endtask

   task automatic report_mismatch(input string what, input longint got, input longint want);
      mismatch_count++;
      $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
   endtask

   // offer one sample word and wait for it to be taken
   task automatic send_word(input logic signed [mstd_pkg::SAMPLE_W-1:0] s, input logic last,
                            input logic given, input list_stats_type given_stats);
      bit             closes;
      list_stats_type stats;
      while (idling_on && $urandom_range(99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_sample      <= s;
      req_sample_last <= last;
      @(posedge clock);
      while (!req_ready) begin
         @(posedge clock);
      end
      fold_sample(s, last, closes, stats);
      if (closes) begin
         pending_stats.push_back(given ? given_stats : stats);
      end
   endtask

   function automatic logic signed [mstd_pkg::SAMPLE_W-1:0] pick_sample(
         input sample_style_type style,
         input logic signed [mstd_pkg::SAMPLE_W-1:0] held);
      logic [31:0] r;
      r = $urandom;
      case (style)
         STYLE_WIDE: begin
            return r[mstd_pkg::SAMPLE_W-1:0];
         end
         STYLE_NEAR_ZERO: begin
            return $signed(16'($urandom_range(16, 0))) - 16'sd8;
         end
         STYLE_EXTREME: begin
            return r[0] ? 16'sh7FFF : 16'sh8000;
         end
         default: begin
            return held;
         end
      endcase
   endfunction

   // stimulus: directed table, then random lists with one list past capacity
   initial begin : stimulus
      int                                   random_items;
      int                                   list_len;
      int                                   len_class;
      bit                                   big_done;
      sample_style_type                     style;
      logic signed [mstd_pkg::SAMPLE_W-1:0] held;
      reset           <= 1'b1;
      req_valid       <= 1'b0;
      req_sample      <= '0;
      req_sample_last <= 1'b0;
      acc_sum         = 0;
      acc_square_sum  = 0;
      acc_count       = 0;
      acc_dropped     = 1'b0;
      mismatch_count  = 0;
      idling_on       = 1'b1;
      rsp_hold_req    = 1'b0;
      random_items    = 0;
      big_done        = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         send_word(directed_rows[i].sample, directed_rows[i].last,
                   directed_rows[i].given, directed_rows[i].want);
      end
      req_valid <= 1'b0;
      // sender waits for the results to drain
      while (pending_stats.size() != 0) begin
         @(posedge clock);
      end

      // receiver holds off at once, so the list queue fills and the input stalls
      rsp_hold_req = 1'b1;
      while (random_items < RANDOM_ITEMS) begin
         idling_on = !(random_items >= CALM_FROM && random_items < CALM_TO);
         if (!big_done && random_items >= BIG_LIST_AT) begin
            // full list of the most negative sample, then words past capacity
            big_done = 1'b1;
            for (int k = 0; k < mstd_pkg::MAX_SAMPLES; k++) begin
               send_word(16'sh8000, 1'b0, 1'b0, NO_STATS);
            end
            for (int k = 0; k < BIG_LIST_EXTRA; k++) begin
               send_word(pick_sample(STYLE_WIDE, '0), k == BIG_LIST_EXTRA - 1, 1'b0, NO_STATS);
            end
            random_items += mstd_pkg::MAX_SAMPLES + BIG_LIST_EXTRA;
            req_valid <= 1'b0;
            while (pending_stats.size() != 0) begin
               @(posedge clock);
            end
         end else begin
            len_class = $urandom_range(9, 0);
            if (len_class < 6) begin
               list_len = $urandom_range(4, 1);
            end else if (len_class < 9) begin
               list_len = $urandom_range(16, 5);
            end else begin
               list_len = $urandom_range(64, 17);
            end
            style = sample_style_type'($urandom_range(3, 0));
            held  = mstd_pkg::SAMPLE_W'($urandom);
            for (int k = 0; k < list_len; k++) begin
               send_word(pick_sample(style, held), k == list_len - 1, 1'b0, NO_STATS);
            end
            random_items += list_len;
         end
      end
      req_valid <= 1'b0;
      idling_on = 1'b1;

      while (pending_stats.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   // result side: random back pressure plus one long hold-off
   initial begin : receiver
      rsp_hold_done = 1'b0;
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_hold_req && !rsp_hold_done) begin
            rsp_hold_done = 1'b1;
            rsp_ready <= 1'b0;
            repeat (RSP_HOLD_CYCLES) @(posedge clock);
         end
         rsp_ready <= !(idling_on && $urandom_range(99) < IDLE_PERCENT);
      end
   end

   // compare each taken result word with the oldest pending stats
   always @(posedge clock) begin : check_results
      list_stats_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_stats.size() == 0) begin
            report_mismatch("result word with nothing pending", longint'(rsp_mean_q8),
                            longint'(0));
         end else begin
            want = pending_stats.pop_front();
            if (rsp_mean_q8 !== want.mean_q8) begin
               report_mismatch("mean_q8", longint'(rsp_mean_q8), longint'(want.mean_q8));
            end
            if (rsp_std_q8 !== want.std_q8) begin
               report_mismatch("std_q8", longint'(rsp_std_q8), longint'(want.std_q8));
            end
            if (rsp_sample_count !== want.sample_count) begin
               report_mismatch("sample_count", longint'(rsp_sample_count),
                               longint'(want.sample_count));
            end
            if (rsp_too_many !== want.too_many) begin
               report_mismatch("too_many", longint'(rsp_too_many), longint'(want.too_many));
            end
         end
      end
   end

   // watchdog on cycles with no word taken on either side
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= IDLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
         end
      end
   end

endmodule
